// ===== src/sju8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sju8_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16384;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    // Register map
    localparam int          CFG_AW           = 3;
    localparam logic        REG_OUT_CAPACITY = 1'b0;
    localparam logic [15:0] CAPACITY_RESET   = 16'd256;

    // Lead byte high nibbles and their index bases
    localparam logic [3:0]  LEAD_HI_8 = 4'h8;
    localparam logic [3:0]  LEAD_HI_9 = 4'h9;
    localparam logic [3:0]  LEAD_HI_E = 4'he;
    localparam logic [13:0] BASE_8    = 14'h0100;
    localparam logic [13:0] BASE_9    = 14'h1100;
    localparam logic [13:0] BASE_E    = 14'h2100;

    typedef struct packed {
        logic        command;
        logic [13:0] table_index;
        logic [15:0] table_value;
        logic [7:0]  source_byte;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        end_report;
        logic        nul_written;
        logic [15:0] byte_count;
        logic        last;
    } t_out_item;

    // One classified source byte on its way to the back end
    typedef struct packed {
        logic        is_char;
        logic        is_nul;
        logic        last_byte;
        logic [15:0] code_point;
    } t_q_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
    } t_utf8;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_back_state;

    // 16-bit code point to one, two or three UTF-8 bytes
    function automatic t_utf8 utf8_encode(input logic [15:0] v);
        t_utf8 r;
        r = '0;
        if (v < 16'h0080) begin
            r.b0  = v[7:0];
            r.len = 2'd1;
        end else if (v < 16'h0800) begin
            r.b0  = 8'hc0 | {3'b000, v[10:6]};
            r.b1  = 8'h80 | {2'b00, v[5:0]};
            r.len = 2'd2;
        end else begin
            r.b0  = 8'he0 | {4'h0, v[15:12]};
            r.b1  = 8'h80 | {2'b00, v[11:6]};
            r.b2  = 8'h80 | {2'b00, v[5:0]};
            r.len = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/sju8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sju8_front
    import sju8_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_q_entry       o_push_entry
);

    logic [15:0] r_table [TABLE_DEPTH];
    logic [15:0] r_rd_data;
    logic [13:0] r_pending;
    logic [13:0] n_pending;
    logic        r_s1_valid;
    logic        r_s1_char;
    logic        r_s1_nul;
    logic        r_s1_last;

    logic        accept;
    logic        is_byte;
    logic [3:0]  lead_hi;
    logic [13:0] lead_base;
    logic [14:0] idx;
    logic        have;
    logic        is_nul;
    logic        char_ok;
    logic        push_need;
    logic        tbl_wr;
    logic        tbl_rd;

    // Stage 1 advances whenever the queue has room
    assign o_in_ready = !r_s1_valid || !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_s1_valid && !i_q_status.full;

    assign is_byte = (i_in_data.command == CMD_BYTE);
    assign lead_hi = i_in_data.source_byte[7:4];

    // Lead byte decoder
    always_comb begin
        unique case (lead_hi)
            LEAD_HI_8: lead_base = BASE_8;
            LEAD_HI_9: lead_base = BASE_9;
            LEAD_HI_E: lead_base = BASE_E;
            default:   lead_base = '0;
        endcase
    end

    // Classify the source byte: trail, NUL, lead or single byte
    always_comb begin
        idx       = '0;
        have      = 1'b0;
        is_nul    = 1'b0;
        n_pending = r_pending;
        if (r_pending != '0) begin
            idx       = {1'b0, r_pending} + {7'b0, i_in_data.source_byte};
            have      = 1'b1;
            n_pending = '0;
        end else if (i_in_data.source_byte == 8'h00) begin
            is_nul = 1'b1;
        end else if (lead_base != '0) begin
            n_pending = lead_base + {2'b00, i_in_data.source_byte[3:0], 8'h00};
        end else begin
            idx  = {7'b0, i_in_data.source_byte};
            have = 1'b1;
        end
        // end of source string drops any pending lead
        if (i_in_data.last_byte) begin
            n_pending = '0;
        end
    end

    assign char_ok   = have && (idx < 15'(TABLE_DEPTH));
    assign push_need = char_ok || is_nul || i_in_data.last_byte;
    assign tbl_rd    = accept && is_byte && char_ok;
    assign tbl_wr    = accept && !is_byte &&
                       ({1'b0, i_in_data.table_index} < 15'(TABLE_DEPTH));

    // Conversion table: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_table[i_in_data.table_index[TBL_AW-1:0]] <= i_in_data.table_value;
        end
        if (tbl_rd) begin
            r_rd_data <= r_table[idx[TBL_AW-1:0]];
        end
    end

    // Pending lead and stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            if (is_byte) begin
                r_pending <= n_pending;
            end
            r_s1_valid <= is_byte && push_need;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_char <= char_ok;
            r_s1_nul  <= is_nul;
            r_s1_last <= i_in_data.last_byte;
        end
    end

    always_comb begin
        o_push_entry.is_char    = r_s1_char;
        o_push_entry.is_nul     = r_s1_nul;
        o_push_entry.last_byte  = r_s1_last;
        o_push_entry.code_point = r_rd_data;
    end

endmodule

`default_nettype wire

// ===== src/sju8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sju8_queue
    import sju8_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_q_entry i_push_entry,
    input  wire logic     i_pop,
    output t_q_entry      o_head,
    output t_q_status     o_status
);

    t_q_entry         r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QPW:0]     r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == (QPW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sju8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sju8_back
    import sju8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_q_entry    i_head,
    input  wire t_q_status   i_q_status,
    output logic             o_pop,
    input  wire logic [15:0] i_capacity,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data
);

    t_back_state r_state;
    t_back_state n_state;

    logic [15:0] r_wc;
    logic        r_stopped;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [1:0]  r_nb;
    logic [1:0]  r_k;
    logic        r_end;
    logic        r_lastb;
    logic        r_o_valid;
    t_out_item   r_o_data;

    t_utf8       enc;
    logic        fits;
    logic        plan_end;
    logic        o_free;
    logic        emit;
    logic        is_data;
    logic        final_res;
    logic        cap_nz;
    logic [7:0]  cur_byte;
    t_out_item   res;

    // Plan for the head entry against the running count and capacity
    assign enc      = utf8_encode(i_head.code_point);
    assign fits     = i_head.is_char &&
                      (({1'b0, r_wc} + 17'(enc.len)) < {1'b0, i_capacity});
    assign plan_end = (i_head.is_char && !fits) || i_head.is_nul || i_head.last_byte;

    assign o_free  = !r_o_valid || i_out_ready;
    assign cap_nz  = (i_capacity != '0);
    assign is_data = (r_k < r_nb);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty && !r_stopped) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (o_free && final_res) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop = !i_q_status.empty;
            B_EMIT:  emit  = o_free;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // Current result: data byte k, or the end report after them
    always_comb begin
        case (r_k)
            2'd0:    cur_byte = r_b0;
            2'd1:    cur_byte = r_b1;
            default: cur_byte = r_b2;
        endcase
        final_res       = is_data ? (!r_end && (r_k == (r_nb - 2'd1))) : 1'b1;
        res.out_byte    = is_data ? cur_byte : 8'h00;
        res.end_report  = !is_data;
        res.nul_written = !is_data && cap_nz;
        res.byte_count  = is_data ? (r_wc + 16'd1) : (cap_nz ? r_wc : 16'd0);
        res.last        = final_res;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_wc      <= '0;
            r_stopped <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && r_stopped && i_head.last_byte) begin
                r_stopped <= 1'b0;
                r_wc      <= '0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
                if (is_data) begin
                    r_wc <= r_wc + 16'd1;
                end else if (r_lastb) begin
                    r_wc      <= '0;
                    r_stopped <= 1'b0;
                end else begin
                    r_stopped <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Plan registers and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && !r_stopped) begin
            r_b0    <= enc.b0;
            r_b1    <= enc.b1;
            r_b2    <= enc.b2;
            r_nb    <= fits ? enc.len : 2'd0;
            r_end   <= plan_end;
            r_lastb <= i_head.last_byte;
            r_k     <= '0;
        end else if (emit && is_data) begin
            r_k <= r_k + 2'd1;
        end
        if (emit) begin
            r_o_data <= res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

`default_nettype wire

// ===== src/shift_jis_to_utf8_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// input     in         i_in_valid / o_in_ready        i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready      o_out_data (t_out_item)
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A new input transaction is taken every cycle while the front queue has room; loads and
// bytes without a result need no queue entry. Each character or end passes the table
// read stage, then the back end takes it off the queue in its idle state and emits its
// results one at a time in its emit state, the end report after any data bytes. The
// back-end sequencer sets the sustained rate. Reset is synchronous; the table is not
// cleared and holds nothing meaningful until loaded. The result register decouples stalls.

module shift_jis_to_utf8_converter_unit
    import sju8_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_capacity;
    logic        cfg_wr;
    logic        q_push;
    t_q_entry    q_push_entry;
    logic        q_pop;
    t_q_entry    q_head;
    t_q_status   q_status;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[CFG_AW-1] == REG_OUT_CAPACITY);
    assign prdata = (paddr[CFG_AW-1] == REG_OUT_CAPACITY) ? {16'h0000, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[15:0];
        end
    end

    sju8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_push_entry (q_push_entry)
    );

    sju8_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (q_push_entry),
        .i_pop        (q_pop),
        .o_head       (q_head),
        .o_status     (q_status)
    );

    sju8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .i_capacity  (r_capacity),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // An end report always closes the results of its transaction
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_report |-> o_out_data.last)
        else $error("end report not marked last");

    // Data bytes never claim the terminator
    a_data_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.end_report |-> !o_out_data.nul_written)
        else $error("data byte flagged as NUL");

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && q_status.empty)
        else $error("result or queue entry present after reset");

endmodule

`default_nettype wire
